FILE: rtl/core/lld_pkg.sv
// ============================================================================
// lld_pkg
// Shared widths, constants, state type and load arithmetic for the
// least-load dispatcher.
// ============================================================================
package lld_pkg;

  localparam int NODE_W     = 4;
  localparam int WEIGHT_W   = 10;
  localparam int LOAD_W     = 20;
  localparam int S_TDATA_W  = 16;
  localparam int M_TDATA_W  = 24;

  localparam logic [LOAD_W-1:0] LOAD_MAX      = 20'd1048575;
  localparam logic [LOAD_W-1:0] LOAD_SENTINEL = 20'd900000;

  localparam logic ACT_DISPATCH = 1'b0;
  localparam logic ACT_COMPLETE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_POST
  } lld_state_t;

  function automatic logic [LOAD_W-1:0] load_add(input logic [LOAD_W-1:0]   load,
                                                 input logic [WEIGHT_W-1:0] weight);
    logic [LOAD_W:0] sum;
    sum = {1'b0, load} + (LOAD_W+1)'(weight);
    return (sum > {1'b0, LOAD_MAX}) ? LOAD_MAX : sum[LOAD_W-1:0];
  endfunction

  function automatic logic [LOAD_W-1:0] load_sub(input logic [LOAD_W-1:0]   load,
                                                 input logic [WEIGHT_W-1:0] weight);
    return (load > LOAD_W'(weight)) ? (load - LOAD_W'(weight)) : '0;
  endfunction

endpackage

FILE: rtl/core/lld_cell.sv
// ============================================================================
// lld_cell
// One node's load counter plus one stage of the least-load search chain.
// ============================================================================
module lld_cell #(
  parameter int IDX_W = 4,
  parameter int IDX   = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [lld_pkg::LOAD_W-1:0] wr_load,
  output logic [lld_pkg::LOAD_W-1:0] load,
  input  logic                      tok_valid_in,
  input  logic [lld_pkg::LOAD_W-1:0] tok_load_in,
  input  logic [IDX_W-1:0]          tok_idx_in,
  output logic                      tok_valid_out,
  output logic [lld_pkg::LOAD_W-1:0] tok_load_out,
  output logic [IDX_W-1:0]          tok_idx_out
);

  always_ff @(posedge clk) begin
    if (rst) begin
      load <= '0;
    end else if (wr_en) begin
      load <= wr_load;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid_out <= 1'b0;
    end else begin
      tok_valid_out <= tok_valid_in;
    end
  end

  // strict compare keeps the lowest index on ties
  always_ff @(posedge clk) begin
    if (load < tok_load_in) begin
      tok_load_out <= load;
      tok_idx_out  <= IDX_W'(IDX);
    end else begin
      tok_load_out <= tok_load_in;
      tok_idx_out  <= tok_idx_in;
    end
  end

endmodule

FILE: rtl/core/least_load_dispatcher.sv
// ============================================================================
// least_load_dispatcher
// Least-loaded back-end selection over a row of per-node load counters.
// ============================================================================
// One input beat is handled at a time. A completion beat goes from acceptance
// to the post step and then back to ready. A dispatch beat first searches:
// the search token walks the row of node cells one cell per cycle, keeping
// the smallest load below 900000 (lowest index on ties, node 0 if none),
// then the picked node is updated and the result loaded into the output
// register. Loads saturate at 1048575 and floor at 0; a completion for a node
// at or above NUM_NODES changes nothing and reports load 0. The output
// register lets the next beat be accepted while a result waits.
module least_load_dispatcher #(
  parameter int NUM_NODES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [lld_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [3:0] node_id, [13:4] weight
  input  logic                          s_axis_tuser,  // [0] action
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [lld_pkg::M_TDATA_W-1:0] m_axis_tdata   // [3:0] chosen_node, [23:4] node_load
);

  localparam int IDX_W = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;
  localparam int CMP_W = (IDX_W + 1 > lld_pkg::NODE_W + 1) ? IDX_W + 1 : lld_pkg::NODE_W + 1;

  lld_pkg::lld_state_t state, state_next;

  logic                         act_q;
  logic [lld_pkg::NODE_W-1:0]   node_q;
  logic [lld_pkg::WEIGHT_W-1:0] weight_q;
  logic [IDX_W-1:0]             pick_idx;

  logic                         out_valid;
  logic [lld_pkg::NODE_W-1:0]   out_node;
  logic [lld_pkg::LOAD_W-1:0]   out_load;

  logic                         tok_valid [NUM_NODES+1];
  logic [lld_pkg::LOAD_W-1:0]   tok_load  [NUM_NODES+1];
  logic [IDX_W-1:0]             tok_idx   [NUM_NODES+1];
  logic [lld_pkg::LOAD_W-1:0]   loads     [NUM_NODES];
  logic [NUM_NODES-1:0]         wr_en;

  logic                         accept;
  logic                         post;
  logic                         node_ok;
  logic [IDX_W-1:0]             rd_idx;
  logic [lld_pkg::LOAD_W-1:0]   rd_load;
  logic [lld_pkg::LOAD_W-1:0]   new_load;
  logic [lld_pkg::NODE_W-1:0]   res_node;
  logic [lld_pkg::LOAD_W-1:0]   res_load;

  assign s_axis_tready = (state == lld_pkg::ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_load, out_node};

  assign tok_valid[0] = accept && (s_axis_tuser == lld_pkg::ACT_DISPATCH);
  assign tok_load[0]  = lld_pkg::LOAD_SENTINEL;
  assign tok_idx[0]   = '0;

  for (genvar i = 0; i < NUM_NODES; i++) begin : g_cell
    assign wr_en[i] = post && ((act_q == lld_pkg::ACT_DISPATCH) || node_ok)
                      && (rd_idx == IDX_W'(i));

    lld_cell #(
      .IDX_W (IDX_W),
      .IDX   (i)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .wr_en         (wr_en[i]),
      .wr_load       (new_load),
      .load          (loads[i]),
      .tok_valid_in  (tok_valid[i]),
      .tok_load_in   (tok_load[i]),
      .tok_idx_in    (tok_idx[i]),
      .tok_valid_out (tok_valid[i+1]),
      .tok_load_out  (tok_load[i+1]),
      .tok_idx_out   (tok_idx[i+1])
    );
  end

  assign node_ok  = CMP_W'(node_q) < CMP_W'(NUM_NODES);
  assign rd_idx   = (act_q == lld_pkg::ACT_COMPLETE) ? IDX_W'(node_q) : pick_idx;
  assign rd_load  = loads[rd_idx];
  assign new_load = (act_q == lld_pkg::ACT_COMPLETE) ? lld_pkg::load_sub(rd_load, weight_q)
                                                     : lld_pkg::load_add(rd_load, weight_q);
  assign res_node = (act_q == lld_pkg::ACT_COMPLETE) ? node_q : lld_pkg::NODE_W'(pick_idx);
  assign res_load = ((act_q == lld_pkg::ACT_COMPLETE) && !node_ok) ? '0 : new_load;
  assign post     = (state == lld_pkg::ST_POST) && (!out_valid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lld_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lld_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (s_axis_tuser == lld_pkg::ACT_DISPATCH) ? lld_pkg::ST_SEARCH
                                                                : lld_pkg::ST_POST;
        end
      end
      lld_pkg::ST_SEARCH: begin
        if (tok_valid[NUM_NODES]) begin
          state_next = lld_pkg::ST_POST;
        end
      end
      lld_pkg::ST_POST: begin
        if (post) begin
          state_next = lld_pkg::ST_IDLE;
        end
      end
      default: state_next = lld_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_q    <= s_axis_tuser;
      node_q   <= s_axis_tdata[lld_pkg::NODE_W-1:0];
      weight_q <= s_axis_tdata[lld_pkg::NODE_W +: lld_pkg::WEIGHT_W];
    end
    if ((state == lld_pkg::ST_SEARCH) && tok_valid[NUM_NODES]) begin
      pick_idx <= tok_idx[NUM_NODES];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (post) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (post) begin
      out_node <= res_node;
      out_load <= res_load;
    end
  end

endmodule

FILE: rtl/core/lld_checker.sv
// ============================================================================
// lld_checker
// Port-level checks for the least-load dispatcher, bound to the top level.
// ============================================================================
module lld_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [lld_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output beat valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output beat changed");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second beat accepted while one is in flight");

  a_result_frees_input: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("result posted without returning to ready");

  a_no_result_at_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == lld_pkg::ACT_DISPATCH
      |=> !$rose(m_axis_tvalid))
    else $error("dispatch result appeared before the search ran");

endmodule

bind least_load_dispatcher lld_checker u_lld_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: sim/tb_least_load_dispatcher.sv
// ----------------------------------------------------------------------------
// tb_least_load_dispatcher
// Self-checking bench for the least-load dispatcher. A clocked driver feeds
// dispatch and completion beats from a request queue. A shadow backlog model
// predicts the picked node and its new load for each accepted beat. A clocked
// monitor compares every output beat with the oldest prediction.
// Stimulus runs in this order: directed corner beats, random traffic under
// four idling phases with a pause until all results are back after the
// twelfth of twenty segments, and final mixed traffic with both sides idling.
// ----------------------------------------------------------------------------
module tb_least_load_dispatcher;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_NODES    = 16;
  localparam int LIMIT_CYCLES = 3_000_000;

  localparam int PH_FREE     = 0;
  localparam int PH_TX_IDLE  = 1;
  localparam int PH_RX_STALL = 2;
  localparam int PH_BOTH     = 3;
  localparam int TX_IDLE_PCT [4] = '{0, 59, 0, 13};
  localparam int RX_STALL_PCT[4] = '{0, 0, 59, 13};

  typedef struct packed {
    logic                         action;
    logic [lld_pkg::NODE_W-1:0]   node_id;
    logic [lld_pkg::WEIGHT_W-1:0] weight;
  } req_t;

  typedef struct packed {
    logic [lld_pkg::NODE_W-1:0] node;
    logic [lld_pkg::LOAD_W-1:0] load;
  } pick_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [lld_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                          s_axis_tuser = lld_pkg::ACT_DISPATCH;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [lld_pkg::M_TDATA_W-1:0] m_axis_tdata;

  least_load_dispatcher #(.NUM_NODES(NUM_NODES)) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  req_t                       request_q[$];
  pick_t                      pending_picks[$];
  req_t                       beat_on_bus;
  logic [lld_pkg::LOAD_W-1:0] backlog[NUM_NODES];
  int                         phase = PH_FREE;
  int                         errors = 0;
  int                         n_dispatch = 0;
  int                         n_complete = 0;
  int                         n_fallback = 0;
  int                         n_saturate = 0;
  int                         n_floor = 0;
  int                         n_checked = 0;

  initial begin
    for (int i = 0; i < NUM_NODES; i++) backlog[i] = '0;
  end

  // least-loaded pick below the sentinel, lowest index on ties, node 0 if none
  function automatic pick_t route_request(req_t r);
    pick_t                      p;
    logic [lld_pkg::LOAD_W-1:0] best;
    int                         idx;
    logic [lld_pkg::LOAD_W:0]   sum;
    if (r.action == lld_pkg::ACT_DISPATCH) begin
      best = lld_pkg::LOAD_SENTINEL;
      idx  = 0;
      for (int i = 0; i < NUM_NODES; i++) begin
        if (backlog[i] < best) begin
          best = backlog[i];
          idx  = i;
        end
      end
      if (best == lld_pkg::LOAD_SENTINEL) n_fallback++;
      sum = {1'b0, backlog[idx]}
            + {{(lld_pkg::LOAD_W+1-lld_pkg::WEIGHT_W){1'b0}}, r.weight};
      if (sum > {1'b0, lld_pkg::LOAD_MAX}) begin
        sum = {1'b0, lld_pkg::LOAD_MAX};
        n_saturate++;
      end
      backlog[idx] = sum[lld_pkg::LOAD_W-1:0];
      p.node = idx[lld_pkg::NODE_W-1:0];
      p.load = backlog[idx];
      n_dispatch++;
    end else begin
      p.node = r.node_id;
      p.load = '0;
      if (int'(r.node_id) < NUM_NODES) begin
        if (backlog[r.node_id] > {{(lld_pkg::LOAD_W-lld_pkg::WEIGHT_W){1'b0}}, r.weight})
          backlog[r.node_id] = backlog[r.node_id]
                               - {{(lld_pkg::LOAD_W-lld_pkg::WEIGHT_W){1'b0}}, r.weight};
        else begin
          backlog[r.node_id] = '0;
          n_floor++;
        end
        p.load = backlog[r.node_id];
      end
      n_complete++;
    end
    return p;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        pending_picks.push_back(route_request(beat_on_bus));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (request_q.size() != 0 && $urandom_range(99) >= TX_IDLE_PCT[phase]) begin
          beat_on_bus = request_q.pop_front();
          s_axis_tdata  <= lld_pkg::S_TDATA_W'({beat_on_bus.weight, beat_on_bus.node_id});
          s_axis_tuser  <= beat_on_bus.action;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    pick_t got;
    pick_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.node = m_axis_tdata[lld_pkg::NODE_W-1:0];
        got.load = m_axis_tdata[lld_pkg::NODE_W +: lld_pkg::LOAD_W];
        if (pending_picks.size() == 0) begin
          $error("unexpected result beat: chosen_node %0d node_load %0d", got.node, got.load);
          errors++;
        end else begin
          want = pending_picks.pop_front();
          n_checked++;
          if (got.node !== want.node) begin
            $error("chosen_node mismatch: expected %0d, actual %0d", want.node, got.node);
            errors++;
          end
          if (got.load !== want.load) begin
            $error("node_load mismatch: expected %0d, actual %0d", want.load, got.load);
            errors++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= RX_STALL_PCT[phase]);
    end
  end

  task automatic push_req(input logic act, input int node, input int w);
    req_t r;
    r.action  = act;
    r.node_id = node[lld_pkg::NODE_W-1:0];
    r.weight  = w[lld_pkg::WEIGHT_W-1:0];
    request_q.push_back(r);
  endtask

  task automatic push_random(input int n, input int pct_dispatch);
    int w;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(7))
        0:       w = 0;
        1:       w = 1023;
        default: w = $urandom_range(1023);
      endcase
      push_req(($urandom_range(99) < pct_dispatch) ? lld_pkg::ACT_DISPATCH
                                                   : lld_pkg::ACT_COMPLETE,
               $urandom_range(NUM_NODES - 1), w);
    end
  endtask

  task automatic drain_all();
    while (request_q.size() != 0 || s_axis_tvalid || pending_picks.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed corners
    @(negedge clk);
    phase = PH_FREE;
    push_req(lld_pkg::ACT_DISPATCH, 0, 0);
    push_req(lld_pkg::ACT_DISPATCH, 0, 1023);
    push_req(lld_pkg::ACT_DISPATCH, 9, 1);
    push_req(lld_pkg::ACT_COMPLETE, 15, 1023);
    push_req(lld_pkg::ACT_COMPLETE, 0, 1023);
    push_req(lld_pkg::ACT_DISPATCH, 3, 512);
    push_req(lld_pkg::ACT_COMPLETE, 1, 0);
    push_req(lld_pkg::ACT_COMPLETE, 1, 1);
    push_req(lld_pkg::ACT_DISPATCH, 0, 'h2AA);
    push_req(lld_pkg::ACT_DISPATCH, 15, 'h155);
    push_req(lld_pkg::ACT_COMPLETE, 10, 'h155);
    push_req(lld_pkg::ACT_COMPLETE, 5, 'h2AA);
    push_req(lld_pkg::ACT_COMPLETE, 0, 100);
    push_req(lld_pkg::ACT_DISPATCH, 0, 7);
    push_req(lld_pkg::ACT_COMPLETE, 2, 1023);
    drain_all();

    // random traffic, idling phase rotates every segment
    for (int seg = 0; seg < 20; seg++) begin
      phase = seg % 4;
      push_random(50, 60);
      while (request_q.size() != 0) @(negedge clk);
      if (seg == 11) drain_all();
    end
    drain_all();

    // mixed traffic, both sides idling
    phase = PH_BOTH;
    push_random(60, 50);
    drain_all();
    repeat (NUM_NODES + 8) @(posedge clk);

    $display("covered %0d dispatch and %0d completion beats, %0d results checked",
             n_dispatch, n_complete, n_checked);
    $display("%0d fallback picks above sentinel, %0d saturated loads, %0d floored loads",
             n_fallback, n_saturate, n_floor);
    if (errors == 0 && pending_picks.size() == 0)
      $display("** least_load_dispatcher: PASSED **");
    else
      $display("** least_load_dispatcher: FAILED **");
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * 10);
    $display("timeout after %0d cycles", LIMIT_CYCLES);
    $display("** least_load_dispatcher: FAILED **");
    $finish;
  end

endmodule
